@@ rtl/dining_philosophers_fork_arbiter_unit_assert.svh @@
// Assertion macros for the fork arbiter; clocked on clk_i, off while rst_ni is low.
`ifndef DINING_PHILOSOPHERS_FORK_ARBITER_UNIT_ASSERT_SVH
`define DINING_PHILOSOPHERS_FORK_ARBITER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DPFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dpfa_pkg.sv @@
// Shared types and constants for the fork arbiter.
package dpfa_pkg;

  localparam int MaxSeatsDef  = 16;
  localparam int InitSeatsDef = 5;

  localparam int KindW   = 2;
  localparam int SeatW   = 4;
  localparam int StatusW = 2;
  localparam int CountW  = 5;
  localparam int MaskW   = 16;

  // Command queue between front and back end.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [KindW-1:0] {
    KIND_TAKE   = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_MIN   = 2'd2,
    STATUS_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [SeatW-1:0] seat;
    logic             seat_ok;  // seat below the table's capacity
  } cmd_t;

  typedef struct packed {
    logic [QCntW-1:0] cnt;
    logic             empty;
    logic             full;
  } q_stat_t;

  typedef struct packed {
    status_e           status;
    logic              self_granted;
    logic              left_granted;
    logic              right_granted;
    logic [CountW-1:0] seated_count;
    logic [MaskW-1:0]  eating_mask;
  } res_t;

endpackage

@@ rtl/dpfa_if.sv @@
// Request and response channel interfaces of the fork arbiter.
interface dpfa_req_if;
  import dpfa_pkg::*;

  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SeatW-1:0] seat;

  modport source (output valid, output kind, output seat, input ready);
  modport sink (input valid, input kind, input seat, output ready);
endinterface

interface dpfa_rsp_if;
  import dpfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               self_granted;
  logic               left_granted;
  logic               right_granted;
  logic [CountW-1:0]  seated_count;
  logic [MaskW-1:0]   eating_mask;

  modport source (output valid, output status, output self_granted, output left_granted,
                  output right_granted, output seated_count, output eating_mask,
                  input ready);
  modport sink (input valid, input status, input self_granted, input left_granted,
                input right_granted, input seated_count, input eating_mask,
                output ready);
endinterface

@@ rtl/dpfa_front.sv @@
// Front end: accepts requests and classifies them into queue commands.
module dpfa_front #(
  parameter int MAX_SEATS = dpfa_pkg::MaxSeatsDef
) (
  dpfa_req_if.sink          req,
  input  dpfa_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output dpfa_pkg::cmd_t    cmd_o
);
  import dpfa_pkg::*;

  localparam int SeatCapW = $clog2(MAX_SEATS + 1);
  localparam int CmpW     = (SeatCapW > SeatW) ? SeatCapW : SeatW;

  assign req.ready = !q_stat_i.full;
  assign push_o    = req.valid && !q_stat_i.full;

  always_comb begin
    cmd_o.kind    = kind_e'(req.kind);
    cmd_o.seat    = req.seat;
    cmd_o.seat_ok = (CmpW'(req.seat) < CmpW'(MAX_SEATS));
  end

endmodule

@@ rtl/dpfa_queue.sv @@
// Short command queue between the front and back end.
module dpfa_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpfa_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output dpfa_pkg::cmd_t    cmd_o,
  output dpfa_pkg::q_stat_t q_stat_o
);
  import dpfa_pkg::*;

  cmd_t             slots_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = QCntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = QCntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = slots_q[rd_ptr_q];
  assign q_stat_o.cnt   = cnt_q;
  assign q_stat_o.empty = (cnt_q == '0);
  assign q_stat_o.full  = (cnt_q == QCntW'(QDepth));

endmodule

@@ rtl/dpfa_back.sv @@
// Back end: seat state, fork arbitration and the registered result.
module dpfa_back #(
  parameter int MAX_SEATS     = dpfa_pkg::MaxSeatsDef,
  parameter int INITIAL_SEATS = dpfa_pkg::InitSeatsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpfa_pkg::cmd_t    cmd_i,
  input  dpfa_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  dpfa_rsp_if.source        rsp
);
  import dpfa_pkg::*;

  localparam int IdxW    = $clog2(MAX_SEATS);
  localparam int CntW    = $clog2(MAX_SEATS + 1);
  localparam int CmpW    = (CntW > SeatW) ? CntW : SeatW;
  localparam int InitEff = (INITIAL_SEATS < MAX_SEATS) ? INITIAL_SEATS : MAX_SEATS;
  localparam int PadW    = (MAX_SEATS > MaskW) ? MAX_SEATS : MaskW;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [MAX_SEATS-1:0] vec_t;

  function automatic idx_t left_of(idx_t i, idx_t last);
    return (i == '0) ? last : idx_t'(i - 1'b1);
  endfunction

  function automatic idx_t right_of(idx_t i, idx_t last);
    return (i == last) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // thinking is neither hungry nor eating
  vec_t            hungry_q, hungry_d, eating_q, eating_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;

  idx_t last, s, sl, sr, sll, slr, srl, srr;
  vec_t oh_s, oh_l, oh_r, h0, e0, h1, e1;
  logic in_range, self_g, gl, gr;
  logic [PadW-1:0] eat_pad;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || rsp.ready);

  always_comb begin
    last     = idx_t'(count_q - 1'b1);
    s        = idx_t'(cmd_i.seat);
    in_range = cmd_i.seat_ok && (CmpW'(cmd_i.seat) < CmpW'(count_q));
    sl       = left_of(s, last);
    sr       = right_of(s, last);
    sll      = left_of(sl, last);
    slr      = right_of(sl, last);
    srl      = left_of(sr, last);
    srr      = right_of(sr, last);
    oh_s     = vec_t'(1) << s;
    oh_l     = vec_t'(1) << sl;
    oh_r     = vec_t'(1) << sr;
    h0       = hungry_q & ~oh_s;
    e0       = eating_q & ~oh_s;
    // take: the seat turns hungry and eats if neither neighbour eats
    self_g   = !e0[sl] && !e0[sr];
    // put: retest left, then right against the updated state
    gl       = h0[sl] && !e0[sll] && !e0[slr];
    e1       = gl ? (e0 | oh_l) : e0;
    h1       = gl ? (h0 & ~oh_l) : h0;
    gr       = h1[sr] && !e1[srl] && !e1[srr];
  end

  always_comb begin
    hungry_d          = hungry_q;
    eating_d          = eating_q;
    count_d           = count_q;
    res_d.status      = STATUS_DONE;
    res_d.self_granted  = 1'b0;
    res_d.left_granted  = 1'b0;
    res_d.right_granted = 1'b0;
    case (cmd_i.kind)
      KIND_TAKE: begin
        if (!in_range) begin
          res_d.status = STATUS_RANGE;
        end else begin
          hungry_d = self_g ? h0 : (h0 | oh_s);
          eating_d = self_g ? (e0 | oh_s) : e0;
          res_d.self_granted = self_g;
        end
      end
      KIND_PUT: begin
        if (!in_range) begin
          res_d.status = STATUS_RANGE;
        end else begin
          hungry_d = gr ? (h1 & ~oh_r) : h1;
          eating_d = gr ? (e1 | oh_r) : e1;
          res_d.left_granted  = gl;
          res_d.right_granted = gr;
        end
      end
      KIND_ADD: begin
        if (count_q >= CntW'(MAX_SEATS)) begin
          res_d.status = STATUS_FULL;
        end else begin
          hungry_d = hungry_q & ~(vec_t'(1) << idx_t'(count_q));
          eating_d = eating_q & ~(vec_t'(1) << idx_t'(count_q));
          count_d  = CntW'(count_q + 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (count_q <= CntW'(InitEff)) begin
          res_d.status = STATUS_MIN;
        end else begin
          // dropped slot goes back to thinking, no retest
          count_d  = CntW'(count_q - 1'b1);
          hungry_d = hungry_q & ~(vec_t'(1) << idx_t'(count_d));
          eating_d = eating_q & ~(vec_t'(1) << idx_t'(count_d));
        end
      end
      default: begin
        res_d.status = STATUS_DONE;
      end
    endcase
    res_d.seated_count = CountW'(count_d);
    eat_pad = PadW'(eating_d);
    for (int i = 0; i < MaskW; i++) begin
      res_d.eating_mask[i] = eat_pad[i] && (i < int'(count_d));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hungry_q    <= '0;
      eating_q    <= '0;
      count_q     <= CntW'(InitEff);
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        hungry_q <= hungry_d;
        eating_q <= eating_d;
        count_q  <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = res_q.status;
  assign rsp.self_granted  = res_q.self_granted;
  assign rsp.left_granted  = res_q.left_granted;
  assign rsp.right_granted = res_q.right_granted;
  assign rsp.seated_count  = res_q.seated_count;
  assign rsp.eating_mask   = res_q.eating_mask;

endmodule

@@ rtl/dining_philosophers_fork_arbiter_unit.sv @@
// Fork arbiter for a ring of dining philosophers: front end, command queue, back end.
//
// Usage:
//   in_i  carries one request per transaction: kind (take, put, add, remove) and seat.
//   out_o returns exactly one result per request, in order: status, grant flags,
//   seated count and the eating mask of seats 0..15.
//   Both channels use valid/ready; a transaction completes when both are high.
// Timing:
//   A request passes through the two-entry command queue and then the result
//   register before it reaches out_o.
//   Sustained rate is one request per cycle while out_o takes results, set by the
//   back end, which updates the seat state and the left-then-right retest as it pops.
// Reset:
//   All seats thinking, seated count at INITIAL_SEATS (capped at MAX_SEATS),
//   queue empty and no result pending.
// Backpressure:
//   While out_o is stalled the result register holds; the back end stops and
//   the queue fills, after which in_i.ready drops. Nothing is lost or repeated.
module dining_philosophers_fork_arbiter_unit #(
  parameter int MAX_SEATS     = dpfa_pkg::MaxSeatsDef,
  parameter int INITIAL_SEATS = dpfa_pkg::InitSeatsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  dpfa_req_if.sink   in_i,
  dpfa_rsp_if.source out_o
);
  import dpfa_pkg::*;

  logic    push, pop;
  cmd_t    cmd_in, cmd_head;
  q_stat_t q_stat;

  dpfa_front #(
    .MAX_SEATS(MAX_SEATS)
  ) u_front (
    .req     (in_i),
    .q_stat_i(q_stat),
    .push_o  (push),
    .cmd_o   (cmd_in)
  );

  dpfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .q_stat_o(q_stat)
  );

  dpfa_back #(
    .MAX_SEATS    (MAX_SEATS),
    .INITIAL_SEATS(INITIAL_SEATS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_head),
    .q_stat_i(q_stat),
    .pop_o   (pop),
    .rsp     (out_o)
  );

  `include "dining_philosophers_fork_arbiter_unit_assert.svh"

  `DPFA_ASSERT_NOW(a_pop_needs_cmd, pop, !q_stat.empty, "pop from empty command queue")
  `DPFA_ASSERT_NEXT(a_pop_gives_result, pop, out_o.valid, "executed command left no result")
  `DPFA_ASSERT_NEXT(a_queue_grows, push && !pop, q_stat.cnt == $past(q_stat.cnt) + 1'b1, "queue count did not grow on push")
  `DPFA_ASSERT_NOW(a_fail_no_grant, out_o.valid && (out_o.status != STATUS_DONE), !out_o.self_granted && !out_o.left_granted && !out_o.right_granted, "grant reported with failed status")

endmodule
